/* rtl/core/inverse_depth_backprojection_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the inverse depth backprojection block
// Concurrent checks clocked on aclk, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DEPTH_BACKPROJECTION_ASSERT_SVH
`define INVERSE_DEPTH_BACKPROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define IDB_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");
`define IDB_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) (prop)) else $error("assertion failed");
`else
`define IDB_ASSERT(label, prop)
`define IDB_ASSERT_RST(label, prop)
`endif
`endif

/* rtl/core/idb_pkg.sv */
// ----------------------------------------------------------------------------
// idb_pkg
// Types, constants and the divider step shared by the backprojection core.
// ----------------------------------------------------------------------------
package idb_pkg;

    localparam int MAX_DIMENSION = 2048;
    localparam int DIV_STAGES    = 32;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FX     = 3'd2;
    localparam logic [2:0] REG_FY     = 3'd3;
    localparam logic [2:0] REG_CX     = 3'd4;
    localparam logic [2:0] REG_CY     = 3'd5;

    typedef struct packed {
        logic [11:0]        width;
        logic [11:0]        height;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } cfg_t;

    typedef struct packed {
        logic [23:0] grad_x;
        logic [23:0] grad_y;
        logic [15:0] intensity;
        logic [22:0] variance;
        logic [21:0] pixel_index;
    } side_t;

    typedef struct packed {
        logic [23:0] rem;
        logic [31:0] sh;
        logic        neg;
        logic        ovf;
    } lane_t;

    typedef struct packed {
        logic        valid;
        logic [23:0] dm;
        lane_t [2:0] lane;
        side_t       side;
    } div_t;

    // one restoring step: next quotient bit enters sh from the bottom
    function automatic lane_t div_step(lane_t l, logic [23:0] dm);
        lane_t       r;
        logic [24:0] r2;
        logic [24:0] diff;
        r    = l;
        r2   = {l.rem, l.sh[31]};
        diff = r2 - {1'b0, dm};
        if (r2 >= {1'b0, dm}) begin
            r.rem = diff[23:0];
            r.sh  = {l.sh[30:0], 1'b1};
        end else begin
            r.rem = r2[23:0];
            r.sh  = {l.sh[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* rtl/core/inverse_depth_backprojection.sv */
// Pipeline: 5 front stages, 32 divider stages and 1 output register, all
// stalled together while the output is held. Throughput: one item per cycle
// when not stalled; the 32-stage quotient pipeline sets depth.
// Dropped pixels leave a bubble and give no result.
// Reset: synchronous, active low; clears valid bits, config registers go to defaults.
// ----------------------------------------------------------------------------
// inverse_depth_backprojection
// Pixel backprojection core: filter, intrinsics, divide, saturate.
// ----------------------------------------------------------------------------
`include "inverse_depth_backprojection_assert.svh"
module inverse_depth_backprojection (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // column, row, inv_depth, depth_variance, intensity, gradient_x, gradient_y
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x, point_y, point_z, grad_x_out, grad_y_out, intensity_out,
    // variance_out, pixel_index
    output logic [207:0] m_tdata
);
    import idb_pkg::*;

    cfg_t        cfg_reg;
    logic        ce;
    div_t        front_out, div_out;
    logic        m_tvalid_reg;
    logic [95:0] pts_reg, pts_next;
    side_t       side_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= 12'd640;
            cfg_reg.height <= 12'd480;
            cfg_reg.fx     <= '0;
            cfg_reg.fy     <= '0;
            cfg_reg.cx     <= '0;
            cfg_reg.cy     <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_WIDTH:  cfg_reg.width  <= pwdata[11:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[11:0];
                REG_FX:     cfg_reg.fx     <= pwdata;
                REG_FY:     cfg_reg.fy     <= pwdata;
                REG_CX:     cfg_reg.cx     <= pwdata;
                REG_CY:     cfg_reg.cy     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WIDTH:  prdata = {20'd0, cfg_reg.width};
            REG_HEIGHT: prdata = {20'd0, cfg_reg.height};
            REG_FX:     prdata = cfg_reg.fx;
            REG_FY:     prdata = cfg_reg.fy;
            REG_CX:     prdata = cfg_reg.cx;
            REG_CY:     prdata = cfg_reg.cy;
            default:    prdata = '0;
        endcase
    end

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    idb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .cfg      (cfg_reg),
        .out      (front_out)
    );

    idb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in      (front_out),
        .out     (div_out)
    );

    // saturate and apply sign
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!div_out.lane[l].neg) begin
                if (div_out.lane[l].ovf || div_out.lane[l].sh[31]) begin
                    pts_next[l*32 +: 32] = 32'h7FFF_FFFF;
                end else begin
                    pts_next[l*32 +: 32] = div_out.lane[l].sh;
                end
            end else begin
                if (div_out.lane[l].ovf || (div_out.lane[l].sh > 32'h8000_0000)) begin
                    pts_next[l*32 +: 32] = 32'h8000_0000;
                end else begin
                    pts_next[l*32 +: 32] = -div_out.lane[l].sh;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pts_reg  <= pts_next;
            side_reg <= div_out.side;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, side_reg.pixel_index, side_reg.variance, side_reg.intensity,
                       side_reg.grad_y, side_reg.grad_x, pts_reg};

    `IDB_ASSERT(a_var_nonzero, m_tvalid_reg |-> (side_reg.variance != 23'd0))
    `IDB_ASSERT(a_rem_lt_dm, div_out.valid |-> (div_out.lane[2].rem < div_out.dm))
    `IDB_ASSERT(a_z_nonzero, m_tvalid_reg |-> (pts_reg[95:64] != 32'd0))
    `IDB_ASSERT(a_out_hold, (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata)))
    `IDB_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid_reg)

endmodule

/* rtl/core/idb_front.sv */
// ----------------------------------------------------------------------------
// idb_front
// Pixel filter, intrinsics multiply, numerator build and divider set-up.
// ----------------------------------------------------------------------------
module idb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [135:0]  in_data,
    input  idb_pkg::cfg_t cfg,
    output idb_pkg::div_t out
);
    import idb_pkg::*;

    // stage 1: capture and filter
    logic        v1_reg, v1_next;
    logic [10:0] x1_reg, y1_reg;
    logic [23:0] d1_reg;
    logic [11:0] w1_reg, w1_next, h_eff;
    side_t       s1_reg;
    logic [10:0] xin, yin;
    logic [23:0] din, varin;

    assign xin   = in_data[10:0];
    assign yin   = in_data[21:11];
    assign din   = in_data[45:22];
    assign varin = in_data[69:46];
    assign w1_next = (cfg.width  > 12'(MAX_DIMENSION)) ? 12'(MAX_DIMENSION) : cfg.width;
    assign h_eff   = (cfg.height > 12'(MAX_DIMENSION)) ? 12'(MAX_DIMENSION) : cfg.height;
    assign v1_next = in_valid && (xin != 11'd0) && (yin != 11'd0)
                  && ({1'b0, xin} + 12'd1 < w1_next) && ({1'b0, yin} + 12'd1 < h_eff)
                  && !varin[23] && (varin != 24'd0) && (din != 24'd0);

    // stage 2: products
    logic               v2_reg;
    logic signed [43:0] px2_reg, py2_reg;
    logic [23:0]        d2_reg;
    side_t              s2_reg;

    // stage 3: numerators
    logic               v3_reg;
    logic signed [44:0] nx3_reg, ny3_reg;
    logic [23:0]        d3_reg;
    side_t              s3_reg;

    // stage 4: magnitudes
    logic        v4_reg;
    logic [43:0] mx4_reg, my4_reg;
    logic        sx4_reg, sy4_reg, sd4_reg;
    logic [23:0] dm4_reg;
    side_t       s4_reg;
    logic signed [44:0] nx_abs, ny_abs;
    logic [23:0] dm_next;

    assign nx_abs  = nx3_reg[44] ? -nx3_reg : nx3_reg;
    assign ny_abs  = ny3_reg[44] ? -ny3_reg : ny3_reg;
    assign dm_next = d3_reg[23] ? 24'(-$signed(d3_reg)) : d3_reg;

    // stage 5: divider set-up
    div_t        o5_reg, o5_next;
    logic [52:0] nxn, nyn, nzn;

    assign nxn = {1'b0, mx4_reg, 8'd0} + {30'd0, dm4_reg[23:1]};
    assign nyn = {1'b0, my4_reg, 8'd0} + {30'd0, dm4_reg[23:1]};
    assign nzn = {21'd1, 32'd0} + {30'd0, dm4_reg[23:1]};

    always_comb begin
        o5_next       = '0;
        o5_next.valid = v4_reg;
        o5_next.dm    = dm4_reg;
        o5_next.side  = s4_reg;
        o5_next.lane[0].ovf = {3'd0, nxn[52:32]} >= dm4_reg;
        o5_next.lane[1].ovf = {3'd0, nyn[52:32]} >= dm4_reg;
        o5_next.lane[2].ovf = {3'd0, nzn[52:32]} >= dm4_reg;
        o5_next.lane[0].rem = o5_next.lane[0].ovf ? 24'd0 : {3'd0, nxn[52:32]};
        o5_next.lane[1].rem = o5_next.lane[1].ovf ? 24'd0 : {3'd0, nyn[52:32]};
        o5_next.lane[2].rem = o5_next.lane[2].ovf ? 24'd0 : {3'd0, nzn[52:32]};
        o5_next.lane[0].sh  = nxn[31:0];
        o5_next.lane[1].sh  = nyn[31:0];
        o5_next.lane[2].sh  = nzn[31:0];
        o5_next.lane[0].neg = sx4_reg ^ sd4_reg;
        o5_next.lane[1].neg = sy4_reg ^ sd4_reg;
        o5_next.lane[2].neg = sd4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            o5_reg.valid <= 1'b0;
        end else if (ce) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            x1_reg <= xin;
            y1_reg <= yin;
            d1_reg <= din;
            w1_reg <= w1_next;
            s1_reg.variance    <= varin[22:0];
            s1_reg.intensity   <= in_data[85:70];
            s1_reg.grad_x      <= in_data[109:86];
            s1_reg.grad_y      <= in_data[133:110];
            s1_reg.pixel_index <= '0;

            px2_reg <= $signed({{12{cfg.fx[31]}}, cfg.fx}) * $signed({33'd0, x1_reg});
            py2_reg <= $signed({{12{cfg.fy[31]}}, cfg.fy}) * $signed({33'd0, y1_reg});
            d2_reg  <= d1_reg;
            s2_reg  <= {s1_reg.grad_x, s1_reg.grad_y, s1_reg.intensity, s1_reg.variance,
                        22'({12'd0, x1_reg} + {12'd0, y1_reg} * {11'd0, w1_reg})};

            nx3_reg <= {px2_reg[43], px2_reg} + 45'($signed(cfg.cx));
            ny3_reg <= {py2_reg[43], py2_reg} + 45'($signed(cfg.cy));
            d3_reg  <= d2_reg;
            s3_reg  <= s2_reg;

            mx4_reg <= nx_abs[43:0];
            my4_reg <= ny_abs[43:0];
            sx4_reg <= nx3_reg[44];
            sy4_reg <= ny3_reg[44];
            sd4_reg <= d3_reg[23];
            dm4_reg <= dm_next;
            s4_reg  <= s3_reg;

            o5_reg <= o5_next;
        end
    end

    assign out = o5_reg;

endmodule

/* rtl/core/idb_div.sv */
// ----------------------------------------------------------------------------
// idb_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module idb_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  idb_pkg::div_t in,
    output idb_pkg::div_t out
);
    import idb_pkg::*;

    div_t st_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                st_reg[i].valid <= 1'b0;
            end
        end else if (ce) begin
            st_reg[0].valid <= in.valid;
            st_reg[0].dm    <= in.dm;
            st_reg[0].side  <= in.side;
            for (int l = 0; l < 3; l++) begin
                st_reg[0].lane[l] <= div_step(in.lane[l], in.dm);
            end
            for (int i = 1; i < DIV_STAGES; i++) begin
                st_reg[i].valid <= st_reg[i-1].valid;
                st_reg[i].dm    <= st_reg[i-1].dm;
                st_reg[i].side  <= st_reg[i-1].side;
                for (int l = 0; l < 3; l++) begin
                    st_reg[i].lane[l] <= div_step(st_reg[i-1].lane[l], st_reg[i-1].dm);
                end
            end
        end
    end

    assign out = st_reg[DIV_STAGES-1];

endmodule

/* verif/inverse_depth_backprojection_tb.sv */
// ----------------------------------------------------------------------------
// inverse_depth_backprojection_tb
// Drives pixels into the backprojection core under several camera settings
// and random flow control, predicts each kept pixel's point and side fields
// in the bench, and compares every result item field by field.
// ----------------------------------------------------------------------------
module inverse_depth_backprojection_tb;
    import idb_pkg::*;

    typedef struct packed {
        logic [10:0]        column;
        logic [10:0]        row;
        logic signed [23:0] inv_depth;
        logic signed [23:0] variance;
        logic [15:0]        intensity;
        logic signed [23:0] grad_x;
        logic signed [23:0] grad_y;
    } pixel_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [23:0] gx;
        logic [23:0] gy;
        logic [15:0] intensity;
        logic [22:0] variance;
        logic [21:0] index;
    } point_t;

    localparam int LIMIT = 2000000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [207:0] m_tdata;

    int unsigned  send_idle = 0;
    int unsigned  recv_idle = 0;
    int unsigned  hold_requests = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_cycles = 0;
    int unsigned  cycles = 0;
    int unsigned  errors = 0;

    logic [11:0]        cam_w = 640, cam_h = 480;
    logic signed [31:0] cam_fx = 0, cam_fy = 0, cam_cx = 0, cam_cy = 0;

    point_t       expected_points[$];

    inverse_depth_backprojection dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] divide_round(longint n, longint d);
        logic        neg;
        logic [63:0] nm, dm, q;
        neg = (n < 0) != (d < 0);
        nm  = n < 0 ? -n : n;
        dm  = d < 0 ? -d : d;
        q   = ((nm << 8) + dm / 2) / dm;
        if (!neg) return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return 32'(-q);
    endfunction

    task automatic predict_point(pixel_t p);
        longint w, h, x, y;
        point_t r;
        w = cam_w > MAX_DIMENSION ? MAX_DIMENSION : cam_w;
        h = cam_h > MAX_DIMENSION ? MAX_DIMENSION : cam_h;
        x = p.column;
        y = p.row;
        if (x < 1 || x >= w - 1 || y < 1 || y >= h - 1) return;
        if (p.variance <= 0 || p.inv_depth == 0) return;
        r.px        = divide_round(longint'(cam_fx) * x + cam_cx, p.inv_depth);
        r.py        = divide_round(longint'(cam_fy) * y + cam_cy, p.inv_depth);
        r.pz        = divide_round(longint'(1) << 24, p.inv_depth);
        r.gx        = p.grad_x;
        r.gy        = p.grad_y;
        r.intensity = p.intensity;
        r.variance  = p.variance[22:0];
        r.index     = 22'(x + y * w);
        expected_points.push_back(r);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel = 1; pwrite = 1; paddr = {idx, 2'b00}; pwdata = value; penable = 0;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_WIDTH:  cam_w = value[11:0];
            REG_HEIGHT: cam_h = value[11:0];
            REG_FX:     cam_fx = value;
            REG_FY:     cam_fy = value;
            REG_CX:     cam_cx = value;
            REG_CY:     cam_cy = value;
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [11:0] w, logic [11:0] h, logic [31:0] fx,
                              logic [31:0] fy, logic [31:0] cx, logic [31:0] cy);
        wait (expected_points.size() == 0);
        repeat (50) @(posedge aclk);
        write_reg(REG_WIDTH, {20'd0, w});
        write_reg(REG_HEIGHT, {20'd0, h});
        write_reg(REG_FX, fx);
        write_reg(REG_FY, fy);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
    endtask

    // entered at a falling edge, returns at a falling edge
    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid = 1;
        s_tdata  = {2'd0, p.grad_y, p.grad_x, p.intensity, p.variance, p.inv_depth,
                    p.row, p.column};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_point(p);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    function automatic pixel_t random_pixel(bit in_frame);
        pixel_t p;
        p = pixel_t'(($bits(pixel_t))'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if (in_frame) begin
            p.column = 11'($urandom_range(cam_w > 2048 ? 2047 : cam_w - 1));
            p.row    = 11'($urandom_range(cam_h > 2048 ? 2047 : cam_h - 1));
            if ($urandom_range(9) != 0) p.variance[23] = 1'b0;
            if ($urandom_range(3) == 0) p.inv_depth = 24'($urandom_range(1, 255));
            if ($urandom_range(5) == 0) p.inv_depth = -p.inv_depth;
        end
        if ($urandom_range(49) == 0) p.inv_depth = '0;
        return p;
    endfunction

    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen   <= hold_requests;
            hold_cycles <= 400;
            m_tready    <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.px        = m_tdata[31:0];
            got.py        = m_tdata[63:32];
            got.pz        = m_tdata[95:64];
            got.gx        = m_tdata[119:96];
            got.gy        = m_tdata[143:120];
            got.intensity = m_tdata[159:144];
            got.variance  = m_tdata[182:160];
            got.index     = m_tdata[204:183];
            if (expected_points.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (got.px != want.px) begin
                    $error("point_x: expected %h got %h", want.px, got.px); errors++;
                end
                if (got.py != want.py) begin
                    $error("point_y: expected %h got %h", want.py, got.py); errors++;
                end
                if (got.pz != want.pz) begin
                    $error("point_z: expected %h got %h", want.pz, got.pz); errors++;
                end
                if (got.gx != want.gx) begin
                    $error("grad_x_out: expected %h got %h", want.gx, got.gx); errors++;
                end
                if (got.gy != want.gy) begin
                    $error("grad_y_out: expected %h got %h", want.gy, got.gy); errors++;
                end
                if (got.intensity != want.intensity) begin
                    $error("intensity_out: expected %h got %h", want.intensity,
                           got.intensity);
                    errors++;
                end
                if (got.variance != want.variance) begin
                    $error("variance_out: expected %h got %h", want.variance,
                           got.variance);
                    errors++;
                end
                if (got.index != want.index) begin
                    $error("pixel_index: expected %h got %h", want.index, got.index);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        pixel_t p;
        set_camera(12'd16, 12'd12, 32'h0100_0000, 32'hFF00_0000, 32'hF800_0000,
                   32'h0800_0000);
        p = '{column: 11'd1, row: 11'd1, inv_depth: 24'h010000, variance: 24'd1,
              intensity: 16'hFFFF, grad_x: 24'h7FFFFF, grad_y: 24'h800000};
        send_pixel(p);
        p.column = 11'd14; p.row = 11'd10; p.intensity = 16'd0; p.grad_x = 24'h800000;
        p.grad_y = 24'h7FFFFF; p.variance = 24'h7FFFFF; send_pixel(p);
        p.column = 11'd0; send_pixel(p);
        p.column = 11'd15; send_pixel(p);
        p.column = 11'd5; p.row = 11'd0; send_pixel(p);
        p.row = 11'd11; send_pixel(p);
        p.row = 11'd2047; p.column = 11'd2047; send_pixel(p);
        p.row = 11'd5; p.variance = 24'd0; send_pixel(p);
        p.variance = 24'h800000; send_pixel(p);
        p.variance = 24'h000100; p.inv_depth = 24'd0; send_pixel(p);
        p.inv_depth = 24'd1; send_pixel(p);
        p.inv_depth = 24'hFFFFFF; send_pixel(p);
        p.inv_depth = 24'h7FFFFF; send_pixel(p);
        p.inv_depth = 24'h800000; send_pixel(p);
        p.inv_depth = 24'h000003; send_pixel(p);
        p.inv_depth = 24'hFFFFFD; send_pixel(p);
        // saturation both ways and widest intrinsics
        set_camera(12'd2048, 12'd2048, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        p.column = 11'd2046; p.row = 11'd2046; p.inv_depth = 24'd1; send_pixel(p);
        p.inv_depth = 24'hFFFFFF; send_pixel(p);
        p.column = 11'd1; p.row = 11'd1; p.inv_depth = 24'h7FFFFF; send_pixel(p);
        p.column = 11'd2047; send_pixel(p);
        // oversize dimensions clamp
        set_camera(12'hFFF, 12'hFFF, 32'h0000_0001, 32'h0000_0001, 32'd0, 32'd0);
        p.column = 11'd2046; p.row = 11'd2046; p.inv_depth = 24'h010000; send_pixel(p);
        p.column = 11'd2047; send_pixel(p);
        set_camera(12'd3, 12'd3, 32'h0080_0000, 32'h0080_0000, 32'd0, 32'd0);
        p.column = 11'd1; p.row = 11'd1; send_pixel(p);
        p.column = 11'd2; send_pixel(p);
        set_camera(12'd2, 12'd2, 32'h0080_0000, 32'h0080_0000, 32'd0, 32'd0);
        p.column = 11'd1; send_pixel(p);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_pixel(random_pixel($urandom_range(9) != 0));
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 150; i++) send_pixel(random_pixel(1));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        test_directed();
        send_idle = 6; recv_idle = 52;
        set_camera(12'd64, 12'd48, $urandom, $urandom, $urandom, $urandom);
        test_random(550);
        send_idle = 52; recv_idle = 6;
        set_camera(12'($urandom_range(3, 4095)), 12'($urandom_range(3, 4095)), $urandom,
                   $urandom, $urandom, $urandom);
        test_random(550);
        send_idle = 0; recv_idle = 0;
        set_camera(12'd640, 12'd480, 32'h0000_6666, 32'h0000_6666, 32'hFF80_0000,
                   32'hFFA0_0000);
        test_backpressure();
        test_random(500);
        wait (expected_points.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
